/* sv/stable_sorted_priority_queue_macros.svh */
// assertion macros for the sorted priority queue
// used by the top level; expects clk and arst_n in scope
`ifndef STABLE_SORTED_PRIORITY_QUEUE_MACROS_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication, disabled in reset
`define SSPQ_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sspq check failed");

// next-cycle implication, disabled in reset
`define SSPQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sspq check failed");

`endif

/* sv/sspq_pkg.sv */
// shared types and constants for the sorted priority queue
// no dependencies
package sspq_pkg;

	localparam int CAPACITY = 128;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam logic [63:0] NEG_INF_BITS = 64'hFFF0_0000_0000_0000;

	typedef enum logic {
		OP_INSERT  = 1'b0,
		OP_EXTRACT = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// request word
	typedef struct packed {
		logic               op;
		logic signed [31:0] key;
		logic [63:0]        value;
	} req_t;

	// response word
	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] payload;
	} rsp_t;

	// one stored entry
	typedef struct packed {
		logic signed [31:0] key;
		logic [63:0]        payload;
	} entry_t;

	// broadcast control to every cell
	typedef struct packed {
		logic   ins;
		logic   ext;
		entry_t fresh;
	} cell_ctl_t;

endpackage

/* sv/sspq_cell.sv */
// one slot of the sorted chain: holds an entry, shifts left or right
// depends on sspq_pkg
module sspq_cell (
	input  logic               clk,
	input  sspq_pkg::cell_ctl_t ctl,
	input  logic               occ,
	input  logic               left_le,
	input  sspq_pkg::entry_t   left_entry,
	input  sspq_pkg::entry_t   right_entry,
	output logic               le,
	output sspq_pkg::entry_t   entry
);
	import sspq_pkg::*;

	entry_t entry_q;

	// an occupied entry stays put on insert when its key is not above the new one
	assign le    = occ && (entry_q.key <= ctl.fresh.key);
	assign entry = entry_q;

	// insert shifts toward the tail, extract shifts toward the head
	always_ff @(posedge clk) begin
		if (ctl.ins && !le) begin
			if (left_le) begin
				entry_q <= ctl.fresh;
			end else begin
				entry_q <= left_entry;
			end
		end else if (ctl.ext) begin
			entry_q <= right_entry;
		end
	end

endmodule

/* sv/stable_sorted_priority_queue.sv */
// Bounded min-priority queue built as a chain of sorted cells.
// Request channel (req_valid, req_stall, req): one word per operation, op selects
// insert (key, value) or extract of the smallest key. Response channel
// (rsp_valid, rsp_stall, rsp): exactly one word per request, in order, with a
// status (ok, full, empty) and the extracted payload, zero on insert and the
// negative infinity bits on an empty extract.
// Equal keys leave in the order they arrived.
// An accepted request waits in the command register, is executed in the next
// cycle and its response is registered in the response register at the end of
// that cycle. No new request is taken while a command holds the command register
// that feeds the cell row, where all cells compare and shift together.
// While a response waits under rsp_stall, req_stall stays high and no further
// request enters; the queue contents hold.
// Reset empties the queue at once (the entry count clears); the cell storage
// itself is not cleared and no clearing pass is needed.
// depends on sspq_pkg, sspq_cell and stable_sorted_priority_queue_macros.svh
`include "stable_sorted_priority_queue_macros.svh"

module stable_sorted_priority_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  sspq_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output sspq_pkg::rsp_t rsp
);
	import sspq_pkg::*;

	logic             cmd_valid_s1;
	req_t             cmd_s1;
	logic [CNT_W-1:0] count_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic             is_full;
	logic             is_empty;
	cell_ctl_t        ctl;
	logic [CAPACITY-1:0] occ;
	logic [CAPACITY-1:0] le;
	entry_t           entries [CAPACITY];

	assign is_full  = (count_q == CNT_W'(CAPACITY));
	assign is_empty = (count_q == '0);

	// accept only when the command slot is free and the response slot is empty or drains
	assign req_stall = cmd_valid_s1 || (rsp_valid_q && rsp_stall);

	// broadcast control for the cell row
	always_comb begin
		ctl.ins           = cmd_valid_s1 && (cmd_s1.op == OP_INSERT) && !is_full;
		ctl.ext           = cmd_valid_s1 && (cmd_s1.op == OP_EXTRACT) && !is_empty;
		ctl.fresh.key     = cmd_s1.key;
		ctl.fresh.payload = cmd_s1.value;
	end

	// cell row
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic   left_le;
		entry_t left_entry;
		entry_t right_entry;

		assign occ[i] = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_head
			assign left_le    = 1'b1;
			assign left_entry = ctl.fresh;
		end else begin : g_mid
			assign left_le    = le[i-1];
			assign left_entry = entries[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_entry = entries[i];
		end else begin : g_body
			assign right_entry = entries[i+1];
		end

		sspq_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.occ         (occ[i]),
			.left_le     (left_le),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.le          (le[i]),
			.entry       (entries[i])
		);
	end

	// command register, entry count and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
			count_q      <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			cmd_valid_s1 <= req_valid && !req_stall;
			if (ctl.ins) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctl.ext) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (cmd_valid_s1) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			cmd_s1 <= req;
		end
		if (cmd_valid_s1) begin
			if (cmd_s1.op == OP_INSERT) begin
				rsp_q.status  <= is_full ? ST_FULL : ST_OK;
				rsp_q.payload <= '0;
			end else if (is_empty) begin
				rsp_q.status  <= ST_EMPTY;
				rsp_q.payload <= NEG_INF_BITS;
			end else begin
				rsp_q.status  <= ST_OK;
				rsp_q.payload <= entries[0].payload;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// checks
	`SSPQ_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CNT_W'(CAPACITY))
	`SSPQ_ASSERT_NEXT(a_cmd_gives_rsp, cmd_valid_s1, rsp_valid)
	`SSPQ_ASSERT_NEXT(a_extract_dec, ctl.ext, count_q == $past(count_q) - CNT_W'(1))
	`SSPQ_ASSERT_IMPL(a_head_sorted, occ[1], entries[0].key <= entries[1].key)

endmodule

/* verif/stable_sorted_priority_queue_tb.sv */
// testbench for the stable sorted priority queue: directed table, then random phases
// a queue-based shadow of the sorted store predicts each response word that the table does not give
// depends on sspq_pkg and the stable_sorted_priority_queue top level
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sspq_pkg::*;

	localparam int HOLD_CYCLES = 400;

	// one row of the directed table; answer is used only where known is set
	typedef struct packed {
		req_t word;
		logic known;
		rsp_t answer;
	} step_row_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	// shadow of the store, kept in key order, and the answers still owed
	entry_t ordered_entries[$];
	rsp_t   pending_answers[$];

	int  mismatches = 0;
	bit  calm = 1'b0;
	int  holds_asked = 0;
	int  holds_taken = 0;
	int  hold_left = 0;

	step_row_t directed_steps [0:20];

	stable_sorted_priority_queue u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// one line per mismatch, counted
	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	// shadow update for one accepted word, giving the response it owes
	function automatic rsp_t queue_answer(input req_t w);
		rsp_t   r;
		entry_t e;
		int     pos;
		r.status  = ST_OK;
		r.payload = '0;
		if (w.op == OP_INSERT) begin
			if (ordered_entries.size() >= CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				// stable placement: behind every key that is equal or smaller
				pos = 0;
				while (pos < ordered_entries.size() && ordered_entries[pos].key <= w.key)
					pos++;
				e.key     = w.key;
				e.payload = w.value;
				ordered_entries.insert(pos, e);
			end
		end else if (ordered_entries.size() == 0) begin
			r.status  = ST_EMPTY;
			r.payload = NEG_INF_BITS;
		end else begin
			e = ordered_entries.pop_front();
			r.payload = e.payload;
		end
		return r;
	endfunction

	// random word; narrow keys crowd into a few values so equal keys are common
	function automatic req_t random_word(input int insert_pct, input int narrow_pct);
		req_t w;
		int   pick;
		w.op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_EXTRACT;
		pick = $urandom_range(0, 99);
		if (pick < narrow_pct) begin
			pick = $urandom_range(0, 8);
			w.key = pick - 4;
		end else if (pick < narrow_pct + 6) begin
			case ($urandom_range(0, 3))
				0: w.key = 32'h8000_0000;
				1: w.key = 32'h7FFF_FFFF;
				2: w.key = 32'h0000_0000;
				default: w.key = 32'hFFFF_FFFF;
			endcase
		end else begin
			w.key = $urandom;
		end
		case ($urandom_range(0, 19))
			0: w.value = 64'h0;
			1: w.value = '1;
			2: w.value = NEG_INF_BITS;
			3: w.value = 64'h7FF8_0000_0000_0001;
			default: w.value = {$urandom, $urandom};
		endcase
		return w;
	endfunction

	// offer one word from a falling edge, return at the falling edge after acceptance
	task automatic send_word(input req_t w, input bit known, input rsp_t answer);
		rsp_t predicted;
		while (!calm && $urandom_range(0, 99) < 26) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= w;
		do @(posedge clk); while (req_stall);
		predicted = queue_answer(w);
		pending_answers.push_back(known ? answer : predicted);
		@(negedge clk);
	endtask

	// sender stands back until every owed response has come
	task automatic pause_sender();
		req_valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic run_phase(input int count, input int insert_pct, input int narrow_pct);
		int k;
		for (k = 0; k < count; k++)
			send_word(random_word(insert_pct, narrow_pct), 1'b0, '0);
	endtask

	// receiver: random stalls, calm stretches and long hold-offs on request
	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_taken != holds_asked) begin
				holds_taken++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= !calm && ($urandom_range(0, 99) < 26);
			end
		end
	end

	// response check against the oldest owed word
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_answers.size() == 0) begin
				report_mismatch($sformatf("unexpected word status %0d payload %h",
					rsp.status, rsp.payload));
			end else begin
				want = pending_answers.pop_front();
				if (rsp.status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						rsp.status, want.status));
				if (rsp.payload !== want.payload)
					report_mismatch($sformatf("payload %h, expected %h",
						rsp.payload, want.payload));
			end
		end
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int i;
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;

		// empty queue, key extremes, equal keys, odd payload patterns
		directed_steps = '{
			'{'{OP_EXTRACT, 32'h0000_0000, 64'h0}, 1'b1, '{ST_EMPTY, NEG_INF_BITS}},
			'{'{OP_INSERT, 32'h0000_0000, 64'h0123_4567_89AB_CDEF}, 1'b1, '{ST_OK, 64'h0}},
			'{'{OP_INSERT, 32'h7FFF_FFFF, 64'hFEDC_BA98_7654_3210}, 1'b1, '{ST_OK, 64'h0}},
			'{'{OP_INSERT, 32'h8000_0000, 64'h0000_0000_0000_0001}, 1'b1, '{ST_OK, 64'h0}},
			'{'{OP_INSERT, 32'hFFFF_FFFF, 64'h7FF8_0000_0000_0001}, 1'b1, '{ST_OK, 64'h0}},
			'{'{OP_INSERT, 32'h0000_0005, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1, '{ST_OK, 64'h0}},
			'{'{OP_INSERT, 32'h0000_0005, 64'h0000_0000_0000_0011}, 1'b1, '{ST_OK, 64'h0}},
			'{'{OP_INSERT, 32'h0000_0005, 64'h0000_0000_0000_0022}, 1'b1, '{ST_OK, 64'h0}},
			'{'{OP_EXTRACT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b0, '{ST_OK, 64'h0}},
			'{'{OP_EXTRACT, 32'h0000_0000, 64'h0}, 1'b0, '{ST_OK, 64'h0}},
			'{'{OP_EXTRACT, 32'h0000_0000, 64'h0}, 1'b0, '{ST_OK, 64'h0}},
			'{'{OP_EXTRACT, 32'h0000_0000, 64'h0}, 1'b0, '{ST_OK, 64'h0}},
			'{'{OP_EXTRACT, 32'h0000_0000, 64'h0}, 1'b0, '{ST_OK, 64'h0}},
			'{'{OP_EXTRACT, 32'h0000_0000, 64'h0}, 1'b0, '{ST_OK, 64'h0}},
			'{'{OP_EXTRACT, 32'h0000_0000, 64'h0}, 1'b0, '{ST_OK, 64'h0}},
			'{'{OP_EXTRACT, 32'h0000_0000, 64'h0}, 1'b1, '{ST_EMPTY, NEG_INF_BITS}},
			'{'{OP_INSERT, 32'h7FFF_FFFF, NEG_INF_BITS}, 1'b1, '{ST_OK, 64'h0}},
			'{'{OP_INSERT, 32'h7FFF_FFFF, 64'h0}, 1'b1, '{ST_OK, 64'h0}},
			'{'{OP_EXTRACT, 32'h0000_0000, 64'h0}, 1'b0, '{ST_OK, 64'h0}},
			'{'{OP_EXTRACT, 32'h0000_0000, 64'h0}, 1'b0, '{ST_OK, 64'h0}},
			'{'{OP_EXTRACT, 32'h8000_0000, '1}, 1'b1, '{ST_EMPTY, NEG_INF_BITS}}
		};

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (i = 0; i <= 20; i++)
			send_word(directed_steps[i].word, directed_steps[i].known,
				directed_steps[i].answer);
		pause_sender();

		// mixed traffic over the full key range
		run_phase(150, 55, 10);
		pause_sender();

		// receiver holds off while the sender keeps pushing; store then runs full
		holds_asked++;
		run_phase(250, 90, 40);
		pause_sender();

		// drain past empty
		run_phase(250, 10, 30);
		pause_sender();

		// no idling on either side, crowded keys
		calm = 1'b1;
		run_phase(200, 55, 70);
		calm = 1'b0;
		pause_sender();

		// fill again with wide keys, then drain and mix
		run_phase(250, 88, 5);
		run_phase(200, 12, 20);
		run_phase(100, 50, 50);

		pause_sender();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
